// ===== rtl/core/jdcm_pkg.sv =====
// Shared types, constants and microprogram for the joystick drive command mapper.
package jdcm_pkg;

    // Field and register widths
    localparam int unsigned W_STICK    = 8;
    localparam int unsigned W_SPEED    = 9;
    localparam int unsigned W_RAD      = 11;
    localparam int unsigned W_STRAIGHT = 15;
    localparam int unsigned W_TURN     = 16;
    localparam int unsigned W_VEL      = 10;
    localparam int unsigned W_CFG_IDX  = 3;
    localparam int unsigned W_CFG_DATA = 15;

    // Datapath widths
    localparam int unsigned W_MUL  = 19;
    localparam int unsigned W_PROD = 2 * W_MUL;
    localparam int unsigned W_SUM  = 19;
    localparam int unsigned W_ROOT = 20;
    localparam int unsigned W_T    = 18;
    localparam int unsigned W_PC   = 5;

    // Register reset values
    localparam logic [W_SPEED-1:0]    RST_MAX_SPEED       = 9'd500;
    localparam logic [W_SPEED-1:0]    RST_DEAD_ZONE       = 9'd100;
    localparam logic [W_RAD-1:0]      RST_MIN_RADIUS      = 11'd100;
    localparam logic [W_RAD-1:0]      RST_MAX_RADIUS      = 11'd2000;
    localparam logic [W_RAD-1:0]      RST_STRAIGHT_LIMIT  = 11'd1700;
    localparam logic [W_STRAIGHT-1:0] RST_STRAIGHT_RADIUS = 15'd8000;

    // Register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_MAX_SPEED       = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_DEAD_ZONE       = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_MIN_RADIUS      = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_MAX_RADIUS      = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_STRAIGHT_LIMIT  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_STRAIGHT_RADIUS = 3'd5;

    // Stick geometry
    localparam logic [W_STICK-1:0] AXIS_FULL   = 8'd255;
    localparam logic [W_STICK-1:0] X_CENTRE    = 8'd127;
    localparam logic [W_STICK-1:0] SPIN_LOW_X  = 8'd30;
    localparam logic [W_STICK-1:0] SPIN_HIGH_X = 8'd230;

    // Reciprocals: floor(n * K >> 25) equals n / D for every n the datapath produces
    localparam int unsigned      RECIP_SHIFT = 25;
    localparam logic [W_MUL-1:0] RECIP_255   = 19'd131587;
    localparam logic [W_MUL-1:0] RECIP_127   = 19'd264209;
    localparam int unsigned      RAD_SHIFT   = 7;   // divide by 128

    localparam logic [W_SUM-1:0]  SQRT_BIT_INIT = 19'h40000;
    localparam logic [W_TURN-1:0] TURN_SPIN_POS = 16'h0001;
    localparam logic [W_TURN-1:0] TURN_SPIN_NEG = 16'hFFFF;

    // Control word fields
    typedef logic [3:0]      t_mul_op;
    typedef logic [1:0]      t_s_op;
    typedef logic [1:0]      t_t_op;
    typedef logic [1:0]      t_jmp;
    typedef logic [W_PC-1:0] t_pc;

    localparam t_mul_op MUL_NONE     = 4'd0;
    localparam t_mul_op MUL_AXIS_X   = 4'd1;
    localparam t_mul_op MUL_AXIS_Y   = 4'd2;
    localparam t_mul_op MUL_RECIP255 = 4'd3;
    localparam t_mul_op MUL_SQ_AX    = 4'd4;
    localparam t_mul_op MUL_SQ_AY    = 4'd5;
    localparam t_mul_op MUL_RAD_HI   = 4'd6;
    localparam t_mul_op MUL_RAD_LO   = 4'd7;
    localparam t_mul_op MUL_RECIP127 = 4'd8;

    localparam t_s_op S_HOLD = 2'd0;
    localparam t_s_op S_LOAD = 2'd1;
    localparam t_s_op S_ADD  = 2'd2;
    localparam t_s_op S_ROOT = 2'd3;

    localparam t_t_op T_HOLD = 2'd0;
    localparam t_t_op T_LOAD = 2'd1;
    localparam t_t_op T_ADD  = 2'd2;

    localparam t_jmp J_NONE = 2'd0;
    localparam t_jmp J_IDLE = 2'd1;
    localparam t_jmp J_LOOP = 2'd2;
    localparam t_jmp J_BUSY = 2'd3;

    // Program addresses
    localparam t_pc PC_IDLE    = 5'd0;
    localparam t_pc PC_AX_MUL  = 5'd1;
    localparam t_pc PC_AX_RCP  = 5'd2;
    localparam t_pc PC_AX_LD   = 5'd3;
    localparam t_pc PC_AY_MUL  = 5'd4;
    localparam t_pc PC_AY_RCP  = 5'd5;
    localparam t_pc PC_AY_LD   = 5'd6;
    localparam t_pc PC_SQ_X    = 5'd7;
    localparam t_pc PC_SQ_Y    = 5'd8;
    localparam t_pc PC_SUM     = 5'd9;
    localparam t_pc PC_ROOT    = 5'd10;
    localparam t_pc PC_RAD_HI  = 5'd11;
    localparam t_pc PC_RAD_LO  = 5'd12;
    localparam t_pc PC_RAD_SUM = 5'd13;
    localparam t_pc PC_RAD_RCP = 5'd14;
    localparam t_pc PC_FINISH  = 5'd15;
    localparam t_pc PC_EMIT    = 5'd16;

    typedef struct packed {
        t_mul_op mul_op;
        logic    ld_ax;
        logic    ld_ay;
        t_s_op   s_op;
        t_t_op   t_op;
        logic    fin;
        logic    emit;
        t_jmp    jmp;
        t_pc     target;
        logic    done;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic loop_more;
        logic out_busy;
    } t_stat;

    // Microprogram ROM
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        begin
            c = '0;
            unique case (pc)
                PC_IDLE: begin
                    c.jmp    = J_IDLE;
                    c.target = PC_IDLE;
                end
                PC_AX_MUL:  c.mul_op = MUL_AXIS_X;
                PC_AX_RCP:  c.mul_op = MUL_RECIP255;
                PC_AX_LD:   c.ld_ax  = 1'b1;
                PC_AY_MUL:  c.mul_op = MUL_AXIS_Y;
                PC_AY_RCP:  c.mul_op = MUL_RECIP255;
                PC_AY_LD:   c.ld_ay  = 1'b1;
                PC_SQ_X:    c.mul_op = MUL_SQ_AX;
                PC_SQ_Y: begin
                    c.mul_op = MUL_SQ_AY;
                    c.s_op   = S_LOAD;
                end
                PC_SUM:     c.s_op   = S_ADD;
                PC_ROOT: begin
                    c.s_op   = S_ROOT;
                    c.jmp    = J_LOOP;
                    c.target = PC_ROOT;
                end
                PC_RAD_HI:  c.mul_op = MUL_RAD_HI;
                PC_RAD_LO: begin
                    c.mul_op = MUL_RAD_LO;
                    c.t_op   = T_LOAD;
                end
                PC_RAD_SUM: c.t_op   = T_ADD;
                PC_RAD_RCP: c.mul_op = MUL_RECIP127;
                PC_FINISH:  c.fin    = 1'b1;
                PC_EMIT: begin
                    c.emit   = 1'b1;
                    c.jmp    = J_BUSY;
                    c.target = PC_EMIT;
                    c.done   = 1'b1;
                end
                default:    c.done   = 1'b1;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/core/jdcm_seq.sv =====
// Step counter and jump logic that walks the mapper microprogram.
module jdcm_seq import jdcm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_idle
);

    t_pc  r_pc;
    t_pc  n_pc;
    logic take;

    assign o_ctrl = ucode(r_pc);
    assign o_idle = (r_pc == PC_IDLE);

    always_comb begin
        unique case (o_ctrl.jmp)
            J_NONE: take = 1'b0;
            J_IDLE: take = !i_stat.in_fire;
            J_LOOP: take = i_stat.loop_more;
            J_BUSY: take = i_stat.out_busy;
        endcase
        priority if (take) begin
            n_pc = o_ctrl.target;
        end else if (o_ctrl.done) begin
            n_pc = PC_IDLE;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/joystick_drive_command_mapper_unit.sv =====
// Top level of the joystick drive command mapper: registers, datapath and output stage.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall, i_stick_x, i_stick_y): one item is one
//    X/Y stick pair. An item is taken at an edge with valid high and stall low.
//  - Output channel (o_out_valid / i_out_stall, o_turn_radius, o_drive_velocity):
//    a result leaves only when the (radius, velocity) pair differs from the last one
//    computed, and always for the first item after reset.
//  - Config port (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): always ready;
//    write only while no item is in flight. Indexes past the last register are dropped.
//  - Timing: a 17-step microprogram runs one shared 19x19 multiplier; the square
//    root loop repeats one step 10 times. The output register loads in the emit
//    step, and the next item is taken only once the sequencer is back in idle.
//    The result stays in the output register while the receiver stalls; a new
//    item is still taken and computed, and the last step holds until the
//    register frees.
//  - Reset: registers return to their defaults, the "sent" flag clears, the
//    output register empties and the sequencer returns to idle.
module joystick_drive_command_mapper_unit import jdcm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic        [W_STICK-1:0]    i_stick_x,
    input  logic        [W_STICK-1:0]    i_stick_y,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [W_TURN-1:0]     o_turn_radius,
    output logic signed [W_VEL-1:0]      o_drive_velocity,
    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic        [W_CFG_IDX-1:0]  i_cfg_index,
    input  logic        [W_CFG_DATA-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [W_SPEED-1:0]    r_max_speed;
    logic [W_SPEED-1:0]    r_dead_zone;
    logic [W_RAD-1:0]      r_min_radius;
    logic [W_RAD-1:0]      r_max_radius;
    logic [W_RAD-1:0]      r_straight_limit;
    logic [W_STRAIGHT-1:0] r_straight_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed       <= RST_MAX_SPEED;
            r_dead_zone       <= RST_DEAD_ZONE;
            r_min_radius      <= RST_MIN_RADIUS;
            r_max_radius      <= RST_MAX_RADIUS;
            r_straight_limit  <= RST_STRAIGHT_LIMIT;
            r_straight_radius <= RST_STRAIGHT_RADIUS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_SPEED:       r_max_speed       <= i_cfg_data[W_SPEED-1:0];
                CFG_DEAD_ZONE:       r_dead_zone       <= i_cfg_data[W_SPEED-1:0];
                CFG_MIN_RADIUS:      r_min_radius      <= i_cfg_data[W_RAD-1:0];
                CFG_MAX_RADIUS:      r_max_radius      <= i_cfg_data[W_RAD-1:0];
                CFG_STRAIGHT_LIMIT:  r_straight_limit  <= i_cfg_data[W_RAD-1:0];
                CFG_STRAIGHT_RADIUS: r_straight_radius <= i_cfg_data[W_STRAIGHT-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_ctrl ctrl;
    t_stat stat;
    logic  seq_idle;
    logic  in_fire;
    logic  out_busy;

    logic [W_SUM-1:0] r_bit;

    assign o_in_stall = !seq_idle;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_busy   = o_out_valid && i_out_stall;

    assign stat.in_fire   = in_fire;
    assign stat.loop_more = (r_bit != W_SUM'(1));
    assign stat.out_busy  = out_busy;

    jdcm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_idle  (seq_idle)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [W_STICK-1:0]  r_x;
    logic [W_STICK-1:0]  r_y;
    logic [W_PROD-1:0]   r_prod;
    logic [W_SPEED-1:0]  r_ax_mag;
    logic [W_SPEED-1:0]  r_ay_mag;
    logic [W_SUM-1:0]    r_sum;
    logic [W_ROOT-1:0]   r_root;
    logic [W_T-1:0]      r_t;
    logic [W_TURN-1:0]   r_rad;
    logic [W_VEL-1:0]    r_vel;

    // latch the stick pair when the item is taken
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_stick_x;
            r_y <= i_stick_y;
        end
    end

    // |2v - 255| of the axis under work
    logic [W_STICK-1:0] stick;
    logic [W_STICK-1:0] axis_mag;

    assign stick    = (ctrl.mul_op == MUL_AXIS_Y) ? r_y : r_x;
    assign axis_mag = stick[W_STICK-1] ? {stick[W_STICK-2:0], 1'b1}
                                       : ~{stick[W_STICK-2:0], 1'b0};

    // radius weights: below centre x*hi + (127-x)*lo, above (255-x)*hi + (x-127)*lo
    logic               x_left;
    logic [W_STICK-1:0] x_hi_w;
    logic [W_STICK-1:0] x_lo_w;

    assign x_left = (r_x < X_CENTRE);
    assign x_hi_w = x_left ? r_x : (AXIS_FULL - r_x);
    assign x_lo_w = x_left ? (X_CENTRE - r_x) : (r_x - X_CENTRE);

    // shared multiplier
    logic [W_MUL-1:0]  mul_a;
    logic [W_MUL-1:0]  mul_b;
    logic [W_PROD-1:0] prod_full;

    always_comb begin
        unique case (ctrl.mul_op)
            MUL_AXIS_X, MUL_AXIS_Y: begin
                mul_a = W_MUL'(r_max_speed);
                mul_b = W_MUL'(axis_mag);
            end
            MUL_RECIP255: begin
                mul_a = r_prod[W_MUL-1:0];
                mul_b = RECIP_255;
            end
            MUL_SQ_AX: begin
                mul_a = W_MUL'(r_ax_mag);
                mul_b = W_MUL'(r_ax_mag);
            end
            MUL_SQ_AY: begin
                mul_a = W_MUL'(r_ay_mag);
                mul_b = W_MUL'(r_ay_mag);
            end
            MUL_RAD_HI: begin
                mul_a = W_MUL'(x_hi_w);
                mul_b = W_MUL'(r_max_radius);
            end
            MUL_RAD_LO: begin
                mul_a = W_MUL'(x_lo_w);
                mul_b = W_MUL'(r_min_radius);
            end
            MUL_RECIP127: begin
                mul_a = W_MUL'(r_t);
                mul_b = RECIP_127;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_op != MUL_NONE) begin
            r_prod <= prod_full;
        end
    end

    // scaled axis magnitude, zeroed inside the dead zone
    logic [W_SPEED-1:0] axis_q;
    logic [W_SPEED-1:0] axis_dz;

    assign axis_q  = r_prod[RECIP_SHIFT +: W_SPEED];
    assign axis_dz = (axis_q <= r_dead_zone) ? '0 : axis_q;

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_ax) begin
            r_ax_mag <= axis_dz;
        end
        if (ctrl.ld_ay) begin
            r_ay_mag <= axis_dz;
        end
    end

    // sum of squares, then one root digit per step
    logic [W_ROOT-1:0] trial;

    assign trial = r_root + W_ROOT'(r_bit);

    always_ff @(posedge i_clk) begin
        unique case (ctrl.s_op)
            S_HOLD: ;
            S_LOAD: r_sum <= r_prod[W_SUM-1:0];
            S_ADD: begin
                // also seed the root loop
                r_sum  <= r_sum + r_prod[W_SUM-1:0];
                r_root <= '0;
                r_bit  <= SQRT_BIT_INIT;
            end
            S_ROOT: begin
                if (W_ROOT'(r_sum) >= trial) begin
                    r_sum  <= r_sum - trial[W_SUM-1:0];
                    r_root <= (r_root >> 1) + W_ROOT'(r_bit);
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        endcase
    end

    // radius numerator accumulator
    always_ff @(posedge i_clk) begin
        unique case (ctrl.t_op)
            T_LOAD:  r_t <= r_prod[W_T-1:0];
            T_ADD:   r_t <= r_t + r_prod[W_T-1:0];
            default: ;
        endcase
    end

    // final radius and velocity
    logic [W_RAD-1:0]      rad_mag;
    logic [W_STRAIGHT-1:0] rad_abs;
    logic [W_TURN-1:0]     rad_pos;
    logic [W_TURN-1:0]     rad_val;
    logic [W_TURN-1:0]     rad_fin;
    logic                  ay_zero;
    logic [W_SPEED-1:0]    root_cap;
    logic [W_VEL-1:0]      vel_pos;
    logic [W_VEL-1:0]      vel_fin;

    assign ay_zero = (r_ay_mag == '0);
    assign rad_mag = x_left ? r_prod[RECIP_SHIFT +: W_RAD] : r_t[RAD_SHIFT +: W_RAD];
    assign rad_abs = (rad_mag > r_straight_limit) ? r_straight_radius : W_STRAIGHT'(rad_mag);
    assign rad_pos = W_TURN'(rad_abs);
    assign rad_val = x_left ? rad_pos : (W_TURN'(0) - rad_pos);

    always_comb begin
        priority if (ay_zero && (r_x < SPIN_LOW_X)) begin
            rad_fin = TURN_SPIN_POS;
        end else if (ay_zero && (r_x > SPIN_HIGH_X)) begin
            rad_fin = TURN_SPIN_NEG;
        end else begin
            rad_fin = rad_val;
        end
    end

    // cap the root at full scale; stick pushed to high Y drives backward
    assign root_cap = (r_root > W_ROOT'(r_max_speed)) ? r_max_speed : r_root[W_SPEED-1:0];
    assign vel_pos  = W_VEL'(root_cap);
    assign vel_fin  = (r_y[W_STICK-1] && !ay_zero) ? (W_VEL'(0) - vel_pos) : vel_pos;

    always_ff @(posedge i_clk) begin
        if (ctrl.fin) begin
            r_rad <= rad_fin;
            r_vel <= vel_fin;
        end
    end

    // ------------------------------------------------------------------
    // Change filter and output register
    // ------------------------------------------------------------------
    logic [W_TURN-1:0] r_last_radius;
    logic [W_VEL-1:0]  r_last_velocity;
    logic              r_sent;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [W_TURN-1:0] r_out_radius;
    logic [W_VEL-1:0]  r_out_velocity;
    logic              emit_step;
    logic              emit_new;

    assign emit_step   = ctrl.emit && !out_busy;
    assign emit_new    = !r_sent || (r_rad != r_last_radius) || (r_vel != r_last_velocity);
    assign n_out_valid = out_busy || (emit_step && emit_new);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_sent          <= 1'b0;
            r_last_radius   <= '0;
            r_last_velocity <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (emit_step) begin
                // refresh the history even when nothing changed
                r_sent          <= 1'b1;
                r_last_radius   <= r_rad;
                r_last_velocity <= r_vel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_step && emit_new) begin
            r_out_radius   <= r_rad;
            r_out_velocity <= r_vel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_turn_radius    = r_out_radius;
    assign o_drive_velocity = r_out_velocity;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer took an item but did not go busy");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.emit))
        else $error("result appeared outside the emit step");

    a_velocity_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_drive_velocity <= $signed({1'b0, r_max_speed})) &&
                         (o_drive_velocity >= -$signed({1'b0, r_max_speed}))))
        else $error("velocity beyond full scale");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the joystick drive command mapper unit.
module tb;
    import jdcm_pkg::*;

    // Register indexes past the end of the list; writes to them must be dropped
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_HI = 3'd7;

    // Stick geometry used by the command prediction
    localparam int FULL_SCALE   = 255;
    localparam int CENTER_X     = 127;
    localparam int SPIN_LEFT_X  = 30;
    localparam int SPIN_RIGHT_X = 230;

    // Run pacing: the SETTLE_CYCLES idle wait covers any item that is still
    // in flight without producing a command
    localparam int          SETTLE_CYCLES = 60;
    localparam int          HOLD_CYCLES   = 500;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 110;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    // Readings that sit on a boundary of the default mapping: dead zone edges,
    // spin thresholds and the center split of the radius map
    localparam bit [W_STICK-1:0] STICK_MARKS [15] = '{
        8'd0, 8'd1, 8'd29, 8'd30, 8'd101, 8'd102, 8'd126, 8'd127,
        8'd128, 8'd153, 8'd154, 8'd230, 8'd231, 8'd254, 8'd255
    };

    typedef struct packed {
        logic signed [W_TURN-1:0] turn;
        logic signed [W_VEL-1:0]  vel;
    } t_drive_cmd;

    // Predicts drive commands from accepted stick pairs and matches them
    // against the commands that leave the block.
    class drive_cmd_board;
        bit [W_SPEED-1:0]    max_speed;
        bit [W_SPEED-1:0]    dead_zone;
        bit [W_RAD-1:0]      min_radius;
        bit [W_RAD-1:0]      max_radius;
        bit [W_RAD-1:0]      straight_limit;
        bit [W_STRAIGHT-1:0] straight_radius;
        int                  last_turn;
        int                  last_vel;
        bit                  sent_before;
        t_drive_cmd          pending_cmds[$];
        int                  errors;
        int                  checked;

        function new();
            max_speed       = RST_MAX_SPEED;
            dead_zone       = RST_DEAD_ZONE;
            min_radius      = RST_MIN_RADIUS;
            max_radius      = RST_MAX_RADIUS;
            straight_limit  = RST_STRAIGHT_LIMIT;
            straight_radius = RST_STRAIGHT_RADIUS;
            last_turn       = 0;
            last_vel        = 0;
            sent_before     = 1'b0;
            errors          = 0;
            checked         = 0;
        endfunction

        function void report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            errors++;
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction

        // Mask to the register width; drop unknown indexes
        function void load_reg(logic [W_CFG_IDX-1:0] idx, logic [W_CFG_DATA-1:0] data);
            case (idx)
                CFG_MAX_SPEED:       max_speed       = data[W_SPEED-1:0];
                CFG_DEAD_ZONE:       dead_zone       = data[W_SPEED-1:0];
                CFG_MIN_RADIUS:      min_radius      = data[W_RAD-1:0];
                CFG_MAX_RADIUS:      max_radius      = data[W_RAD-1:0];
                CFG_STRAIGHT_LIMIT:  straight_limit  = data[W_RAD-1:0];
                CFG_STRAIGHT_RADIUS: straight_radius = data[W_STRAIGHT-1:0];
                default: ;
            endcase
        endfunction

        // Scale one reading to -max_speed..max_speed, truncated toward zero
        function int scaled_axis(bit [W_STICK-1:0] v);
            int m;
            int dz;
            int a;
            m  = int'(max_speed);
            dz = int'(dead_zone);
            a  = (m * (2 * int'(v) - FULL_SCALE)) / FULL_SCALE;
            if (a >= -dz && a <= dz) begin
                a = 0;
            end
            return a;
        endfunction

        // Work out the command for an accepted pair; queue it only if it changed
        function void note_pair(bit [W_STICK-1:0] x, bit [W_STICK-1:0] y);
            int ax;
            int ay;
            int xi;
            int lo;
            int hi;
            int lim;
            int sq;
            int vel;
            int rad;
            t_drive_cmd cmd;
            ax  = scaled_axis(x);
            ay  = scaled_axis(y);
            xi  = int'(x);
            lo  = int'(min_radius);
            hi  = int'(max_radius);
            lim = int'(straight_limit);

            // floor square root of the summed squares, then cap and sign
            sq  = ax * ax + ay * ay;
            vel = 0;
            while ((vel + 1) * (vel + 1) <= sq) begin
                vel++;
            end
            if (vel > int'(max_speed)) begin
                vel = int'(max_speed);
            end
            if (ay > 0) begin
                vel = -vel;
            end

            // separate linear maps left and right of center
            if (xi < CENTER_X) begin
                rad = (xi * (hi - lo) + CENTER_X * lo) / CENTER_X;
            end else begin
                rad = ((xi - CENTER_X) * (hi - lo) - 128 * hi) / 128;
            end
            if (rad > lim) begin
                rad = int'(straight_radius);
            end else if (rad < -lim) begin
                rad = -int'(straight_radius);
            end
            if (ay == 0 && xi < SPIN_LEFT_X) begin
                rad = 1;
            end else if (ay == 0 && xi > SPIN_RIGHT_X) begin
                rad = -1;
            end

            if (!sent_before || rad != last_turn || vel != last_vel) begin
                cmd.turn = rad[W_TURN-1:0];
                cmd.vel  = vel[W_VEL-1:0];
                pending_cmds.push_back(cmd);
            end
            last_turn   = rad;
            last_vel    = vel;
            sent_before = 1'b1;
        endfunction

        function void check_cmd(logic signed [W_TURN-1:0] turn,
                                logic signed [W_VEL-1:0] vel);
            t_drive_cmd want;
            checked++;
            if (pending_cmds.size() == 0) begin
                report($sformatf("command %0d (%0d, %0d) with nothing expected",
                                 checked, turn, vel));
            end else begin
                want = pending_cmds.pop_front();
                if (turn !== want.turn) begin
                    report($sformatf("command %0d turn_radius got %0d want %0d",
                                     checked, turn, want.turn));
                end
                if (vel !== want.vel) begin
                    report($sformatf("command %0d drive_velocity got %0d want %0d",
                                     checked, vel, want.vel));
                end
            end
        endfunction
    endclass

    // Clock, reset and every block input start at a known value
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [W_STICK-1:0]    i_stick_x   = '0;
    logic [W_STICK-1:0]    i_stick_y   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [W_CFG_IDX-1:0]  i_cfg_index = '0;
    logic [W_CFG_DATA-1:0] i_cfg_data  = '0;

    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [W_TURN-1:0] o_turn_radius;
    logic signed [W_VEL-1:0]  o_drive_velocity;
    logic                     o_cfg_ready;

    drive_cmd_board board;
    int unsigned    cycle_count = 0;
    int             in_idle_pct = 0;
    int             out_idle_pct = 0;
    bit             hold_off_req = 1'b0;

    joystick_drive_command_mapper_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_stick_x        (i_stick_x),
        .i_stick_y        (i_stick_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_turn_radius    (o_turn_radius),
        .o_drive_velocity (o_drive_velocity),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watch all three channels at the edge. Register writes go first so that
    // the prediction always runs with the settings in force.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.load_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_pair(i_stick_x, i_stick_y);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_cmd(o_turn_radius, o_drive_velocity);
            end
        end
    end

    // Receiver: stall in short random bursts, or hold off for a long stretch
    // on request so that the output register fills and the input backs up.
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                i_out_stall  <= 1'b0;
                hold_off_req = 1'b0;
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one stick pair and hold it until taken. An optional sender gap
    // comes first, so valid is never dropped and raised in the same step.
    task automatic push_pair(input bit [W_STICK-1:0] x, input bit [W_STICK-1:0] y);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_stick_x  <= x;
        i_stick_y  <= y;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int speed, input int dz, input int lo,
                                 input int hi, input int lim, input int srad);
        write_reg(CFG_MAX_SPEED, speed[W_CFG_DATA-1:0]);
        write_reg(CFG_DEAD_ZONE, dz[W_CFG_DATA-1:0]);
        write_reg(CFG_MIN_RADIUS, lo[W_CFG_DATA-1:0]);
        write_reg(CFG_MAX_RADIUS, hi[W_CFG_DATA-1:0]);
        write_reg(CFG_STRAIGHT_LIMIT, lim[W_CFG_DATA-1:0]);
        write_reg(CFG_STRAIGHT_RADIUS, srad[W_CFG_DATA-1:0]);
    endtask

    // Wait until every predicted command has left, then let any item that
    // produces no command finish its pass through the sequencer.
    task automatic quiesce();
        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [W_STICK-1:0] pick_reading();
        if ($urandom_range(0, 99) < 25) begin
            return STICK_MARKS[$urandom_range(0, 14)];
        end
        return W_STICK'($urandom_range(0, 255));
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        bit [W_STICK-1:0] x;
        bit [W_STICK-1:0] y;

        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs on the reset settings: first command, repeats,
        // spin thresholds, dead zone edges and the stick corners
        in_idle_pct  = 15;
        out_idle_pct = 15;
        push_pair(8'd127, 8'd127);
        push_pair(8'd127, 8'd127);   // same pair: no command
        push_pair(8'd127, 8'd130);   // new pair, same command: no command
        push_pair(8'd0, 8'd127);
        push_pair(8'd29, 8'd127);
        push_pair(8'd30, 8'd127);
        push_pair(8'd230, 8'd127);
        push_pair(8'd231, 8'd127);
        push_pair(8'd255, 8'd127);
        push_pair(8'd127, 8'd153);
        push_pair(8'd127, 8'd154);
        push_pair(8'd127, 8'd102);
        push_pair(8'd127, 8'd101);
        push_pair(8'd154, 8'd127);
        push_pair(8'd0, 8'd0);
        push_pair(8'd255, 8'd255);
        push_pair(8'd0, 8'd255);
        push_pair(8'd255, 8'd0);
        push_pair(8'd126, 8'd0);
        push_pair(8'd127, 8'd255);
        push_pair(8'd128, 8'd200);
        push_pair(8'd200, 8'd60);
        push_pair(8'd60, 8'd200);
        i_in_valid <= 1'b0;
        quiesce();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    // defaults, with a long receiver hold-off up front
                    apply_setting(500, 100, 100, 2000, 1700, 8000);
                    in_idle_pct  = 0;
                    out_idle_pct = 20;
                    hold_off_req = 1'b1;
                end
                1: begin
                    // all data bits set: every register reads all ones
                    apply_setting(32767, 32767, 32767, 32767, 32767, 32767);
                    write_reg(CFG_SPARE_LO, 15'h7FFF);
                    write_reg(CFG_SPARE_HI, 15'h7FFF);
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                2: begin
                    apply_setting(1, 0, 1, 1, 0, 0);
                    in_idle_pct  = 20;
                    out_idle_pct = 30;
                end
                3: begin
                    // zero speed and a reversed radius slope
                    apply_setting(0, 0, 2000, 1, 0, 32767);
                    in_idle_pct  = 40;
                    out_idle_pct = 10;
                end
                4: begin
                    apply_setting(500, 500, 2000, 2000, 2000, 32767);
                    in_idle_pct  = 10;
                    out_idle_pct = 40;
                end
                5, 6: begin
                    apply_setting($urandom_range(1, 500), $urandom_range(0, 120),
                                  $urandom_range(1, 2000), $urandom_range(1, 2000),
                                  $urandom_range(0, 2000), $urandom_range(0, 32767));
                    write_reg(CFG_SPARE_LO, W_CFG_DATA'($urandom_range(0, 32767)));
                    in_idle_pct  = 30;
                    out_idle_pct = (phase == 5) ? 30 : 50;
                end
                default: begin
                    // final stretch runs without idling on either side
                    apply_setting(250, 20, 300, 1500, 1000, 1234);
                    write_reg(CFG_SPARE_HI, W_CFG_DATA'($urandom_range(0, 32767)));
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase

            x = pick_reading();
            y = pick_reading();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // repeat the last pair now and then to exercise the no-change path
                if ($urandom_range(0, 99) >= 15) begin
                    x = pick_reading();
                    y = pick_reading();
                end
                push_pair(x, y);
                if (phase == 4 && n == PHASE_ITEMS / 2) begin
                    // sender pause until everything in flight has drained
                    i_in_valid <= 1'b0;
                    quiesce();
                end
            end
            i_in_valid <= 1'b0;
            quiesce();
        end

        if (board.outstanding() != 0) begin
            board.report($sformatf("%0d expected commands never arrived",
                                   board.outstanding()));
        end
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop if the run hangs on a handshake
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TIMEOUT after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== joystick_drive_command_mapper_unit.f =====
rtl/core/jdcm_pkg.sv
rtl/core/jdcm_seq.sv
rtl/core/joystick_drive_command_mapper_unit.sv
sim/tb.sv
